### design/fpr_pkg.sv
// ----------------------------------------------------------------------------
// Framed packet receiver package
// Framing codes and the request that starts a result burst.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_ETX = 8'h03;
  localparam logic [7:0] CODE_EOT = 8'h04;

  localparam int HDR_BYTES = 6;

  typedef struct packed {
    logic       go;
    logic       status;
    logic       has_data;
    logic [6:0] length;
    logic [7:0] sender;
    logic [7:0] command;
  } fpr_start_t;

endpackage

### design/fpr_frame.sv
// ----------------------------------------------------------------------------
// Framed packet receiver framer
// Hunts for headers, stores the payload, checks trailer and checksum.
// ----------------------------------------------------------------------------
module fpr_frame import fpr_pkg::*; #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW          = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  logic [7:0]    rx_byte,
  input  logic [7:0]    own_address,
  input  logic [7:0]    broadcast_address,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output fpr_start_t    start
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_DATA = 3'd1;
  localparam logic [2:0] PH_ETX  = 3'd2;
  localparam logic [2:0] PH_SUM  = 3'd3;
  localparam logic [2:0] PH_EOT  = 3'd4;

  logic [7:0] win [HDR_BYTES];
  logic [2:0] phase;
  logic [6:0] position;
  logic [7:0] exp_len;
  logic [7:0] cmd;
  logic [7:0] sender;
  logic [7:0] sum;
  logic [7:0] rsum;

  logic       hdr_hit;
  logic       dest_ok;
  logic [7:0] hdr_sum;
  logic [6:0] pos_inc;

  assign hdr_hit = (win[1] == CODE_SOH) && (rx_byte == CODE_STX) && (win[2] != win[3]);
  assign dest_ok = (win[2] == own_address) || (win[2] == broadcast_address);
  assign hdr_sum = win[2] + win[3] + win[4] + win[5];
  assign pos_inc = position + 7'd1;

  assign wr_en   = fire && (phase == PH_DATA);
  assign wr_addr = position[AW-1:0];
  assign wr_data = rx_byte;

  always_comb begin
    start          = '0;
    start.go       = fire && (phase == PH_EOT) && (rx_byte == CODE_EOT);
    start.status   = (rsum != sum);
    start.has_data = (rsum == sum) && (exp_len != 8'd0);
    start.length   = exp_len[6:0];
    start.sender   = sender;
    start.command  = cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
        win[i] <= 8'd0;
      end
      phase    <= PH_HUNT;
      position <= 7'd0;
      exp_len  <= 8'd0;
      cmd      <= 8'd0;
      sender   <= 8'd0;
      sum      <= 8'd0;
      rsum     <= 8'd0;
    end else if (fire) begin
      unique case (phase)
        PH_HUNT: begin
          for (int i = 0; i < HDR_BYTES - 1; i++) begin
            win[i] <= win[i+1];
          end
          win[HDR_BYTES-1] <= rx_byte;
          if (hdr_hit) begin
            sender   <= win[3];
            position <= 7'd0;
            rsum     <= 8'd0;
            if (!dest_ok || (win[5] > 8'(MAX_PAYLOAD))) begin
              exp_len <= 8'd0;
              cmd     <= 8'd0;
              sum     <= 8'd0;
            end else begin
              cmd     <= win[4];
              exp_len <= win[5];
              sum     <= hdr_sum;
              phase   <= (win[5] == 8'd0) ? PH_ETX : PH_DATA;
            end
          end
        end
        PH_DATA: begin
          position <= pos_inc;
          sum      <= sum + rx_byte;
          if ({1'b0, pos_inc} >= exp_len) begin
            phase <= PH_ETX;
          end
        end
        PH_ETX: begin
          if (rx_byte == CODE_ETX) begin
            phase <= PH_SUM;
          end else begin
            phase    <= PH_HUNT;
            position <= 7'd0;
            exp_len  <= 8'd0;
            cmd      <= 8'd0;
            sum      <= 8'd0;
            rsum     <= 8'd0;
          end
        end
        PH_SUM: begin
          rsum  <= rx_byte;
          phase <= PH_EOT;
        end
        default: begin
          phase    <= PH_HUNT;
          position <= 7'd0;
          exp_len  <= 8'd0;
          cmd      <= 8'd0;
          sum      <= 8'd0;
          rsum     <= 8'd0;
        end
      endcase
    end
  end

endmodule

### design/fpr_emit.sv
// ----------------------------------------------------------------------------
// Framed packet receiver result emitter
// Holds payload memory; after EOT emits a result per byte, or one if no data.
// ----------------------------------------------------------------------------
module fpr_emit import fpr_pkg::*; #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW          = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  fpr_start_t    start,
  output logic          out_valid,
  input  logic          out_ready,
  output logic          status,
  output logic          has_data,
  output logic          last,
  output logic [7:0]    sender,
  output logic [7:0]    command,
  output logic [6:0]    length,
  output logic [5:0]    byte_index,
  output logic [7:0]    payload_byte
);

  logic [7:0] mem [MAX_PAYLOAD];
  logic [7:0] rdata;

  logic       take;
  logic       rd_en;
  logic [5:0] idx_next;
  logic       hd_next;
  logic [6:0] len_next;

  assign take     = out_valid && out_ready;
  assign hd_next  = start.go ? start.has_data : has_data;
  assign len_next = start.go ? start.length : length;
  assign idx_next = start.go ? 6'd0 : byte_index + 6'd1;
  assign rd_en    = (start.go && start.has_data) || (take && !last);

  assign payload_byte = has_data ? rdata : 8'd0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[idx_next[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (start.go) begin
      out_valid <= 1'b1;
    end else if (take && last) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start.go) begin
      status  <= start.status;
      sender  <= start.sender;
      command <= start.command;
    end
    if (start.go || take) begin
      has_data   <= hd_next;
      length     <= len_next;
      byte_index <= idx_next;
      last       <= hd_next ? ((7'(idx_next) + 7'd1) == len_next) : 1'b1;
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start.go |-> !out_valid)
    else $error("burst started while a result was pending");

  a_nodata_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_data |-> last)
    else $error("result without data is not the last one");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_data |-> (7'(byte_index) < length))
    else $error("byte index beyond payload length");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && (byte_index == $past(byte_index) + 6'd1))
    else $error("burst did not advance to the next byte");
`endif

endmodule

### design/framed_packet_receiver.sv
// The first result of a packet is valid in the cycle after its EOT request.
// Throughput: one line byte per cycle while receiving; a good packet then
// streams one result per cycle while m_tready is high, from the payload memory's registered read port.
// The input is held off from EOT until the last result of that packet is taken.
// Reset (rst, synchronous) clears control state and the address registers; the payload
// memory is not cleared, and is only read at entries the current packet wrote.
// ----------------------------------------------------------------------------
// Framed packet receiver
// SOH/STX/ETX/EOT packet receiver with APB address registers.
// ----------------------------------------------------------------------------
module framed_packet_receiver import fpr_pkg::*; #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] sender, [15:8] command, [22:16] payload_length,
                                 // [28:23] byte_index, [36:29] payload_byte, [39:37] zero
  output logic [1:0]  m_tuser,   // [0] status, [1] has_data
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]    own_address;
  logic [7:0]    broadcast_address;
  logic          fire;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  fpr_start_t    start;
  logic          status;
  logic          has_data;
  logic [7:0]    sender;
  logic [7:0]    command;
  logic [6:0]    length;
  logic [5:0]    byte_index;
  logic [7:0]    payload_byte;

  assign pready   = 1'b1;
  assign s_tready = !m_tvalid;
  assign fire     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address       <= 8'd0;
      broadcast_address <= 8'd0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        broadcast_address <= pwdata[7:0];
      end else begin
        own_address <= pwdata[7:0];
      end
    end
  end

  assign prdata = {24'd0, paddr[2] ? broadcast_address : own_address};

  fpr_frame #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_frame (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .rx_byte           (s_tdata),
    .own_address       (own_address),
    .broadcast_address (broadcast_address),
    .wr_en             (wr_en),
    .wr_addr           (wr_addr),
    .wr_data           (wr_data),
    .start             (start)
  );

  fpr_emit #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_emit (
    .clk          (clk),
    .rst          (rst),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .start        (start),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .status       (status),
    .has_data     (has_data),
    .last         (m_tlast),
    .sender       (sender),
    .command      (command),
    .length       (length),
    .byte_index   (byte_index),
    .payload_byte (payload_byte)
  );

  assign m_tdata = {3'd0, payload_byte, byte_index, length, command, sender};
  assign m_tuser = {has_data, status};

endmodule

### dv/tb_framed_packet_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Framed packet receiver testbench
// Drives line bytes through the stream input and programs the station and
// broadcast addresses over APB. A scoreboard tracks the receive state machine
// byte by byte, queues the packet bytes, error report or empty-packet report that each EOT should
// release, and checks every result that leaves the block against them.
// ----------------------------------------------------------------------------
module tb_framed_packet_receiver;
  import fpr_pkg::*;

  localparam int MAX_PAYLOAD = 32;
  localparam logic [2:0] REG_OWN_ADDR = 3'd0;
  localparam logic [2:0] REG_BCAST_ADDR = 3'd4;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 3000;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_PAYLOAD = 3'd1,
    PH_ETX = 3'd2,
    PH_SUM = 3'd3,
    PH_EOT = 3'd4
  } rx_phase_t;

  typedef enum int {PKT_GOOD, PKT_BAD_SUM, PKT_NO_ETX, PKT_NO_EOT} pkt_kind_t;

  typedef struct packed {
    logic       status;
    logic [7:0] sender;
    logic [7:0] command;
    logic [6:0] length;
    logic [5:0] index;
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } rx_result_t;

  class packet_scoreboard;
    logic [7:0] own_addr = 8'h00;
    logic [7:0] bcast_addr = 8'h00;
    logic [7:0] window [6] = '{default: 8'h00};
    rx_phase_t  phase = PH_HUNT;
    logic [6:0] position = 7'd0;
    logic [7:0] frame_len = 8'h00;
    logic [7:0] frame_cmd = 8'h00;
    logic [7:0] frame_src = 8'h00;
    logic [7:0] sum_calc = 8'h00;
    logic [7:0] sum_rcvd = 8'h00;
    logic [7:0] payload [MAX_PAYLOAD];
    rx_result_t results_due [$];
    int failures = 0;

    function void load_register(logic [2:0] addr, logic [7:0] value);
      case (addr)
        REG_OWN_ADDR: own_addr = value;
        REG_BCAST_ADDR: bcast_addr = value;
        default: ;
      endcase
    endfunction

    function void restart_hunt();
      phase = PH_HUNT;
      position = 7'd0;
      frame_len = 8'h00;
      frame_cmd = 8'h00;
      sum_calc = 8'h00;
      sum_rcvd = 8'h00;
    endfunction

    function void emit(logic status, logic [5:0] idx, logic [7:0] data, logic has,
                       logic last);
      rx_result_t r;
      r.status = status;
      r.sender = frame_src;
      r.command = frame_cmd;
      r.length = frame_len[6:0];
      r.index = idx;
      r.data = data;
      r.has_data = has;
      r.last = last;
      results_due.push_back(r);
    endfunction

    function void take_line_byte(logic [7:0] b);
      int k;
      case (phase)
        PH_HUNT: begin
          for (k = 0; k < 5; k++) window[k] = window[k + 1];
          window[5] = b;
          if (window[0] == CODE_SOH && window[5] == CODE_STX && window[1] != window[2]) begin
            frame_src = window[2];
            frame_cmd = window[3];
            frame_len = window[4];
            sum_calc = window[1] + window[2] + window[3] + window[4];
            position = 7'd0;
            sum_rcvd = 8'h00;
            if (window[1] != own_addr && window[1] != bcast_addr) begin
              restart_hunt();
            end else if (frame_len == 0) begin
              phase = PH_ETX;
            end else if (frame_len > MAX_PAYLOAD) begin
              restart_hunt();
            end else begin
              phase = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          if (position < MAX_PAYLOAD) payload[position] = b;
          position = position + 7'd1;
          sum_calc = sum_calc + b;
          if (position >= frame_len) phase = PH_ETX;
        end
        PH_ETX: begin
          if (b == CODE_ETX) phase = PH_SUM;
          else restart_hunt();
        end
        PH_SUM: begin
          sum_rcvd = b;
          phase = PH_EOT;
        end
        PH_EOT: begin
          if (b == CODE_EOT) begin
            if (sum_rcvd != sum_calc) begin
              emit(1'b1, 6'd0, 8'h00, 1'b0, 1'b1);
            end else if (frame_len == 0) begin
              emit(1'b0, 6'd0, 8'h00, 1'b0, 1'b1);
            end else begin
              for (k = 0; k < frame_len && k < MAX_PAYLOAD; k++)
                emit(1'b0, k[5:0], payload[k], 1'b1, k + 1 == frame_len);
            end
          end
          restart_hunt();
        end
        default: restart_hunt();
      endcase
    endfunction

    function string describe(rx_result_t r);
      return $sformatf({"status %0d sender %02h command %02h length %0d index %0d ",
                        "byte %02h has_data %0d last %0d"},
                       r.status, r.sender, r.command, r.length, r.index, r.data,
                       r.has_data, r.last);
    endfunction

    function void check_packet_byte(rx_result_t got);
      rx_result_t want;
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= 10) $display("Unexpected result: %s", describe(got));
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          failures++;
          if (failures <= 10) begin
            $display("Mismatch: expected %s", describe(want));
            $display("          actual   %s", describe(got));
          end
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  packet_scoreboard sb = new;
  logic [7:0] line_bytes [$];
  rx_result_t seen_result;
  logic sender_calm = 1'b0;
  logic rx_calm = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int results_taken = 0;
  int quiet_cycles = 0;

  framed_packet_receiver #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  assign seen_result = {m_tuser[0], m_tdata[7:0], m_tdata[15:8], m_tdata[22:16],
                        m_tdata[28:23], m_tdata[36:29], m_tuser[1], m_tlast};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (m_tvalid && m_tready) begin
      sb.check_packet_byte(seen_result);
      results_taken++;
    end
    rx_calm = results_taken >= 40 && results_taken < 120;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (rx_calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 24);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_register(input logic [2:0] addr, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.load_register(addr, value);
    @(posedge clk);
  endtask

  function automatic void queue_packet(logic [7:0] dest, logic [7:0] src, logic [7:0] cmd,
                                       logic [7:0] len, pkt_kind_t kind, int fill);
    logic [7:0] sum;
    logic [7:0] pb;
    logic [7:0] stray;
    line_bytes.push_back(CODE_SOH);
    line_bytes.push_back(dest);
    line_bytes.push_back(src);
    line_bytes.push_back(cmd);
    line_bytes.push_back(len);
    line_bytes.push_back(CODE_STX);
    if (len > MAX_PAYLOAD) return;
    sum = dest + src + cmd + len;
    for (int i = 0; i < len; i++) begin
      pb = (fill < 0) ? 8'($urandom) : fill[7:0];
      line_bytes.push_back(pb);
      sum = sum + pb;
    end
    stray = 8'($urandom_range(0, 255));
    case (kind)
      PKT_NO_ETX: begin
        line_bytes.push_back((stray == CODE_ETX) ? CODE_EOT : stray);
      end
      PKT_BAD_SUM: begin
        line_bytes.push_back(CODE_ETX);
        line_bytes.push_back(sum ^ 8'($urandom_range(1, 255)));
        line_bytes.push_back(CODE_EOT);
      end
      PKT_NO_EOT: begin
        line_bytes.push_back(CODE_ETX);
        line_bytes.push_back(sum);
        line_bytes.push_back((stray == CODE_EOT) ? CODE_ETX : stray);
      end
      default: begin
        line_bytes.push_back(CODE_ETX);
        line_bytes.push_back(sum);
        line_bytes.push_back(CODE_EOT);
      end
    endcase
  endfunction

  // Mostly well-formed packets with small payloads, some noise and broken frames.
  function automatic void queue_random_traffic(int nbytes);
    int target;
    int pick;
    logic [7:0] dest;
    logic [7:0] src;
    logic [7:0] len;
    pkt_kind_t kind;
    target = line_bytes.size() + nbytes;
    while (line_bytes.size() < target) begin
      if ($urandom_range(0, 99) < 8) begin
        repeat ($urandom_range(1, 6)) line_bytes.push_back(8'($urandom));
      end else begin
        pick = $urandom_range(0, 9);
        dest = (pick < 4) ? sb.own_addr : (pick < 7) ? sb.bcast_addr : 8'($urandom);
        src = 8'($urandom);
        if (src == dest && $urandom_range(0, 4) != 0) src = dest + 8'd1;
        pick = $urandom_range(0, 19);
        if (pick == 0) len = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
        else if (pick == 1) len = MAX_PAYLOAD;
        else if (pick < 4) len = 8'd0;
        else len = 8'($urandom_range(1, 8));
        pick = $urandom_range(0, 19);
        if (pick < 2) kind = PKT_BAD_SUM;
        else if (pick == 2) kind = PKT_NO_ETX;
        else if (pick == 3) kind = PKT_NO_EOT;
        else kind = PKT_GOOD;
        queue_packet(dest, src, 8'($urandom), len, kind, -1);
      end
    end
  endfunction

  task automatic send_queued();
    logic [7:0] b;
    while (line_bytes.size() > 0) begin
      b = line_bytes.pop_front();
      if (!sender_calm && $urandom_range(0, 99) < 24) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= b;
      do @(posedge clk); while (!s_tready);
      sb.take_line_byte(b);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_register(REG_OWN_ADDR, 8'h5A);
    write_register(REG_BCAST_ADDR, 8'hFF);

    queue_packet(8'h5A, 8'h10, 8'h00, 8'd1, PKT_GOOD, -1);
    queue_packet(8'hFF, 8'h00, 8'hFF, 8'd0, PKT_GOOD, -1);
    queue_packet(8'h5A, 8'hFF, 8'h81, 8'd3, PKT_BAD_SUM, -1);
    queue_packet(8'h5A, 8'h21, 8'h02, 8'd0, PKT_BAD_SUM, -1);
    queue_packet(8'h33, 8'h5A, 8'h01, 8'd2, PKT_GOOD, -1);
    queue_packet(8'h5A, 8'h5A, 8'h01, 8'd2, PKT_GOOD, -1);
    queue_packet(8'h5A, 8'h01, 8'h07, 8'd33, PKT_GOOD, -1);
    queue_packet(8'hFF, 8'h12, 8'h7E, 8'd255, PKT_GOOD, -1);
    queue_packet(8'h5A, 8'h44, 8'h10, 8'd2, PKT_NO_ETX, -1);
    queue_packet(8'h5A, 8'h45, 8'h11, 8'd2, PKT_NO_EOT, -1);
    send_queued();

    // The result sink holds m_tready low while full-size packets are sent, so the input backs up.
    hold_requests++;
    queue_packet(8'h5A, 8'h01, 8'hFF, 8'd32, PKT_GOOD, 255);
    queue_packet(8'hFF, 8'h02, 8'h00, 8'd32, PKT_GOOD, 0);
    queue_packet(8'h5A, 8'hFE, 8'h55, 8'd4, PKT_GOOD, -1);
    send_queued();
    settle();

    write_register(REG_OWN_ADDR, 8'h00);
    write_register(REG_BCAST_ADDR, 8'h00);
    queue_random_traffic(55);
    send_queued();
    settle();

    write_register(REG_OWN_ADDR, 8'hFF);
    write_register(REG_BCAST_ADDR, 8'h00);
    sender_calm = 1'b1;
    queue_random_traffic(55);
    send_queued();
    sender_calm = 1'b0;
    settle();

    write_register(REG_OWN_ADDR, 8'($urandom));
    write_register(REG_BCAST_ADDR, 8'($urandom));
    queue_random_traffic(55);
    send_queued();

    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.results_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
